// File: hw/rtl/sdre_pkg.sv
// Shared widths, coefficients and fixed-point helpers for the seawater density pipeline.
`default_nettype none

package sdre_pkg;

  // Field widths at the ports.
  localparam int T_W   = 23;
  localparam int S_W   = 22;
  localparam int OUT_W = 27;

  // Internal working formats.
  localparam int POLY_W = 44;
  localparam int PROD_W = T_W + POLY_W;
  localparam int F48_W  = 33;
  localparam int ROOT_W = 27;
  localparam int SQ_X_W = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 3;

  // Square root: one result bit per step.
  localparam int SQ_STEPS  = ROOT_W;
  localparam int SQ_PER    = 7;
  localparam int SQ_STAGES = (SQ_STEPS + SQ_PER - 1) / SQ_PER;

  // Polynomial stages between the conditioned inputs and num/den.
  localparam int POLY_STAGES = 5;

  // Division: the Q32 / Q40 ratio needs 2^8 more, plus one guard bit for rounding.
  localparam int DIV_SCALE  = 9;
  localparam int Q_BITS     = OUT_W + 1;
  localparam int DIV_PER    = 4;
  localparam int DIV_STAGES = (Q_BITS + DIV_PER - 1) / DIV_PER;

  // Numerator coefficients.
  localparam logic signed [POLY_W-1:0] NUM_C0 = 44'sd4294283771061;
  localparam logic signed [POLY_W-1:0] NUM_C1 = 44'sd504893168411;
  localparam logic signed [POLY_W-1:0] NUM_C2 = -44'sd936101889352;
  localparam logic signed [POLY_W-1:0] NUM_C3 = 44'sd6419817780;
  localparam logic signed [POLY_W-1:0] NUM_S0 = 44'sd177849929840;
  localparam logic signed [POLY_W-1:0] NUM_S1 = 44'sd118163692707;
  localparam logic signed [POLY_W-1:0] NUM_S2 = 44'sd33782630321;
  // Denominator coefficients.
  localparam logic signed [POLY_W-1:0] DEN_C0 = 44'sd1099511627776;
  localparam logic signed [POLY_W-1:0] DEN_C1 = 44'sd128097872318;
  localparam logic signed [POLY_W-1:0] DEN_C2 = -44'sd201703912046;
  localparam logic signed [POLY_W-1:0] DEN_C3 = 44'sd390275492717;
  localparam logic signed [POLY_W-1:0] DEN_C4 = 44'sd157387648;
  localparam logic signed [POLY_W-1:0] DEN_S0 = 44'sd496300244353;
  localparam logic signed [POLY_W-1:0] DEN_S1 = 44'sd634586610422;
  localparam logic signed [POLY_W-1:0] DEN_S2 = 44'sd217126126;
  localparam logic signed [POLY_W-1:0] DEN_R0 = 44'sd414070149661;
  localparam logic signed [POLY_W-1:0] DEN_R1 = 44'sd1696671046;

  // Result flags that ride along the divider.
  typedef struct packed {
    logic zero;
    logic sat;
  } sdre_flag_t;

  // Temperature-sized operand times a polynomial-sized operand.
  function automatic logic signed [PROD_W-1:0] mul_t(input logic signed [T_W-1:0] a,
                                                    input logic signed [POLY_W-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // Round half up of p / 2^k.
  function automatic logic signed [POLY_W-1:0] rnd(input logic signed [PROD_W-1:0] p,
                                                  input int unsigned k);
    logic signed [PROD_W-1:0] v;
    v = p + (PROD_W'(1) << (k - 1));
    return POLY_W'(v >>> k);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdre_sqrt.sv
// Pipelined digit-by-digit integer square root of salinity scaled by 2^32.
`default_nettype none

module sdre_sqrt (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [sdre_pkg::S_W-1:0]       s_in,
  output logic      [sdre_pkg::ROOT_W-1:0]    root_out
);

  logic [sdre_pkg::SQ_REM_W-1:0] rem_r  [sdre_pkg::SQ_STAGES];
  logic [sdre_pkg::ROOT_W-1:0]   root_r [sdre_pkg::SQ_STAGES];
  logic [sdre_pkg::S_W-1:0]      s_r    [sdre_pkg::SQ_STAGES];

  for (genvar st = 0; st < sdre_pkg::SQ_STAGES; st++) begin : g_st
    logic [sdre_pkg::SQ_REM_W-1:0] rem_in, rem_nxt;
    logic [sdre_pkg::ROOT_W-1:0]   root_in, root_nxt;
    logic [sdre_pkg::S_W-1:0]      s_cur;

    if (st == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_cur   = s_in;
    end else begin : g_next
      assign rem_in  = rem_r[st-1];
      assign root_in = root_r[st-1];
      assign s_cur   = s_r[st-1];
    end

    always_comb begin
      logic [sdre_pkg::SQ_X_W-1:0]   x;
      logic [sdre_pkg::SQ_REM_W-1:0] rem2;
      logic [sdre_pkg::SQ_REM_W-1:0] trial;
      int j;
      x        = {s_cur, (sdre_pkg::SQ_X_W - sdre_pkg::S_W)'(0)};
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int k = 0; k < sdre_pkg::SQ_PER; k++) begin
        j = st * sdre_pkg::SQ_PER + k;
        if (j < sdre_pkg::SQ_STEPS) begin
          rem2  = {rem_nxt[sdre_pkg::SQ_REM_W-3:0], x[sdre_pkg::SQ_X_W-1-2*j -: 2]};
          trial = {1'b0, root_nxt, 2'b01};
          if (rem2 >= trial) begin
            rem_nxt  = rem2 - trial;
            root_nxt = {root_nxt[sdre_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem_nxt  = rem2;
            root_nxt = {root_nxt[sdre_pkg::ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st]  <= rem_nxt;
        root_r[st] <= root_nxt;
        s_r[st]    <= s_cur;
      end
    end
  end

  assign root_out = root_r[sdre_pkg::SQ_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/sdre_poly.sv
// Five-stage pipeline that evaluates the numerator and denominator polynomials.
`default_nettype none

module sdre_poly (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [sdre_pkg::T_W-1:0]     t_in,
  input  wire logic        [sdre_pkg::S_W-1:0]     s_in,
  input  wire logic        [sdre_pkg::ROOT_W-1:0]  root_in,
  output logic signed      [sdre_pkg::POLY_W-1:0]  num_out,
  output logic signed      [sdre_pkg::POLY_W-1:0]  den_out
);

  localparam int W = sdre_pkg::POLY_W;

  logic signed [sdre_pkg::T_W-1:0] t1_r, t2_r, t3_r;
  logic signed [sdre_pkg::T_W-1:0] s1_r, s2_r, s3_r, s4_r;
  logic signed [W-1:0] n3_r, h_r, d3_r, u_r, v_r;
  logic signed [W-1:0] n2_r, d2_r, e_r, f_r, sh2_r;
  logic signed [W-1:0] n1_r, d1_r, te_r, sh3_r;
  logic signed [sdre_pkg::F48_W-1:0] f48_r;
  logic signed [W-1:0] num4_r, d0_r, g_r;
  logic signed [W-1:0] num5_r, den5_r;
  logic signed [sdre_pkg::T_W-1:0] s_sgn;
  logic signed [sdre_pkg::PROD_W-1:0] rf_prod;

  assign s_sgn   = $signed({1'b0, s_in});
  assign rf_prod = sdre_pkg::PROD_W'($signed({1'b0, root_in})) * sdre_pkg::PROD_W'(f48_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // Innermost terms: products of temperature or salinity by constants.
      t1_r <= t_in;
      s1_r <= s_sgn;
      n3_r <= sdre_pkg::NUM_C2 + sdre_pkg::rnd(sdre_pkg::mul_t(t_in, sdre_pkg::NUM_C3), 16);
      h_r  <= sdre_pkg::NUM_S0 - sdre_pkg::rnd(sdre_pkg::mul_t(t_in, sdre_pkg::NUM_S1), 24)
              + sdre_pkg::rnd(sdre_pkg::mul_t(s_sgn, sdre_pkg::NUM_S2), 24);
      d3_r <= sdre_pkg::DEN_C3 + sdre_pkg::rnd(sdre_pkg::mul_t(t_in, sdre_pkg::DEN_C4), 16);
      u_r  <= sdre_pkg::rnd(sdre_pkg::mul_t(t_in, sdre_pkg::DEN_S2), 16);
      v_r  <= sdre_pkg::rnd(sdre_pkg::mul_t(t_in, sdre_pkg::DEN_R1), 16);

      t2_r  <= t1_r;
      s2_r  <= s1_r;
      n2_r  <= sdre_pkg::NUM_C1 + sdre_pkg::rnd(sdre_pkg::mul_t(t1_r, n3_r), 24);
      d2_r  <= sdre_pkg::DEN_C2 + sdre_pkg::rnd(sdre_pkg::mul_t(t1_r, d3_r), 24);
      e_r   <= sdre_pkg::DEN_S1 + sdre_pkg::rnd(sdre_pkg::mul_t(t1_r, u_r), 20);
      f_r   <= sdre_pkg::DEN_R0 + sdre_pkg::rnd(sdre_pkg::mul_t(t1_r, v_r), 20);
      sh2_r <= sdre_pkg::rnd(sdre_pkg::mul_t(s1_r, h_r), 20);

      t3_r  <= t2_r;
      s3_r  <= s2_r;
      n1_r  <= sdre_pkg::NUM_C0 + sdre_pkg::rnd(sdre_pkg::mul_t(t2_r, n2_r), 20);
      d1_r  <= sdre_pkg::DEN_C1 + sdre_pkg::rnd(sdre_pkg::mul_t(t2_r, d2_r), 24);
      f48_r <= sdre_pkg::F48_W'(sdre_pkg::rnd(sdre_pkg::PROD_W'(f_r), 8));
      te_r  <= sdre_pkg::rnd(sdre_pkg::mul_t(t2_r, e_r), 24);
      sh3_r <= sh2_r;

      // The square root arrives here, aligned with the third stage.
      s4_r   <= s3_r;
      num4_r <= n1_r + sh3_r;
      d0_r   <= sdre_pkg::DEN_C0 + sdre_pkg::rnd(sdre_pkg::mul_t(t3_r, d1_r), 20);
      g_r    <= sdre_pkg::DEN_S0 - te_r + sdre_pkg::rnd(rf_prod, 24);

      num5_r <= num4_r;
      den5_r <= d0_r + sdre_pkg::rnd(sdre_pkg::mul_t(s4_r, g_r), 24);
    end
  end

  assign num_out = num5_r;
  assign den_out = den5_r;

endmodule

`default_nettype wire

// File: hw/rtl/sdre_div.sv
// Pipelined restoring divider that forms the scaled density quotient and its flags.
`default_nettype none

module sdre_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [sdre_pkg::POLY_W-1:0]  num_in,
  input  wire logic signed [sdre_pkg::POLY_W-1:0]  den_in,
  output logic             [sdre_pkg::Q_BITS-1:0]  q_out,
  output sdre_pkg::sdre_flag_t                     flag_out
);

  localparam int RW = sdre_pkg::POLY_W - 1;
  localparam int QB = sdre_pkg::Q_BITS;
  localparam int NW = RW + sdre_pkg::DIV_SCALE + FRAC_BITS;

  logic                   num_pos, den_pos, ovf;
  logic [NW-1:0]          n_wide;
  logic [NW-QB-1:0]       r_init;
  sdre_pkg::sdre_flag_t   flag_c;

  logic [RW-1:0]        rem0_r, den0_r;
  logic [QB-1:0]        low0_r;
  sdre_pkg::sdre_flag_t flg0_r;

  logic [RW-1:0]        rem_r [sdre_pkg::DIV_STAGES];
  logic [RW-1:0]        den_r [sdre_pkg::DIV_STAGES];
  logic [QB-1:0]        low_r [sdre_pkg::DIV_STAGES];
  logic [QB-1:0]        q_r   [sdre_pkg::DIV_STAGES];
  sdre_pkg::sdre_flag_t flg_r [sdre_pkg::DIV_STAGES];

  assign num_pos = !num_in[sdre_pkg::POLY_W-1] && (num_in != '0);
  assign den_pos = !den_in[sdre_pkg::POLY_W-1] && (den_in != '0);
  assign n_wide  = {num_in[RW-1:0], (sdre_pkg::DIV_SCALE + FRAC_BITS)'(0)};
  assign r_init  = n_wide[NW-1:QB];
  // The quotient needs more than its bits exactly when the top of the dividend reaches den.
  assign ovf     = NW'(r_init) >= NW'(den_in[RW-1:0]);

  always_comb begin
    flag_c.zero = den_pos && !num_pos;
    flag_c.sat  = !den_pos || (num_pos && ovf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= RW'(r_init);
      den0_r <= den_in[RW-1:0];
      low0_r <= n_wide[QB-1:0];
      flg0_r <= flag_c;
    end
  end

  for (genvar st = 0; st < sdre_pkg::DIV_STAGES; st++) begin : g_st
    logic [RW-1:0]        rem_in, den_cur, rem_nxt;
    logic [QB-1:0]        low_in, q_in, low_nxt, q_nxt;
    sdre_pkg::sdre_flag_t flg_in;

    if (st == 0) begin : g_first
      assign rem_in  = rem0_r;
      assign den_cur = den0_r;
      assign low_in  = low0_r;
      assign q_in    = '0;
      assign flg_in  = flg0_r;
    end else begin : g_next
      assign rem_in  = rem_r[st-1];
      assign den_cur = den_r[st-1];
      assign low_in  = low_r[st-1];
      assign q_in    = q_r[st-1];
      assign flg_in  = flg_r[st-1];
    end

    always_comb begin
      logic [RW:0] trial;
      rem_nxt = rem_in;
      low_nxt = low_in;
      q_nxt   = q_in;
      for (int k = 0; k < sdre_pkg::DIV_PER; k++) begin
        if (st * sdre_pkg::DIV_PER + k < QB) begin
          trial   = {rem_nxt, low_nxt[QB-1]};
          low_nxt = {low_nxt[QB-2:0], 1'b0};
          if (trial >= {1'b0, den_cur}) begin
            rem_nxt = RW'(trial - {1'b0, den_cur});
            q_nxt   = {q_nxt[QB-2:0], 1'b1};
          end else begin
            rem_nxt = trial[RW-1:0];
            q_nxt   = {q_nxt[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st] <= rem_nxt;
        den_r[st] <= den_cur;
        low_r[st] <= low_nxt;
        q_r[st]   <= q_nxt;
        flg_r[st] <= flg_in;
      end
    end
  end

  assign q_out    = q_r[sdre_pkg::DIV_STAGES-1];
  assign flag_out = flg_r[sdre_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/seawater_density_rational_eos.sv
// Top level of the seawater density pipeline at surface pressure.
`default_nettype none

// Channel   Direction  Ports                                   Per transaction
// in_       input      in_valid, in_stall, in_temperature,     one grid point
//                      in_salinity
// out_      output     out_valid, out_stall, out_density       one density value
//
// One transaction enters per clock while the pipeline is not frozen; its path runs
// through the input register, the five polynomial multiply stages with the square
// root running beside them, the divider setup register, the seven stages of the
// restoring divider (four quotient bits each) and the output register.
// Reset (rst_n low, synchronous) clears only the valid bits of the pipeline.
// When the output holds a transaction and out_stall is high, the whole pipeline
// freezes and in_stall goes high; nothing is dropped or repeated.

module seawater_density_rational_eos #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sdre_pkg::T_W-1:0]     in_temperature,
  input  wire logic        [sdre_pkg::S_W-1:0]     in_salinity,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [sdre_pkg::OUT_W-1:0]   out_density
);

  localparam int T_W = sdre_pkg::T_W;
  localparam int S_W = sdre_pkg::S_W;
  localparam int QB  = sdre_pkg::Q_BITS;
  // Input register, polynomial stages, divider setup, divider stages, output register.
  localparam int LAT = 1 + sdre_pkg::POLY_STAGES + 1 + sdre_pkg::DIV_STAGES + 1;

  logic                          en;
  logic [LAT-1:0]                vld_r, vld_nxt;
  logic signed [T_W-1:0]         t16_c, t0_r;
  logic [S_W-1:0]                s16_c, s0_r;
  logic [sdre_pkg::ROOT_W-1:0]   root;
  logic signed [sdre_pkg::POLY_W-1:0] num, den;
  logic [QB-1:0]                 q;
  sdre_pkg::sdre_flag_t          flag;
  logic [QB:0]                   q_sum;
  logic [QB-1:0]                 q_rnd;
  logic [sdre_pkg::OUT_W-1:0]    dens_nxt, dens_r;

  // The pipeline moves as one; it holds only while a finished transaction waits.
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = vld_r[LAT-1] && out_stall;

  // Bring both inputs to 16 fraction bits. A finer format is rounded half up;
  // a coarser one is clamped to the range the 16-bit format can hold.
  if (FRAC_BITS > 16) begin : g_fine
    localparam int K = FRAC_BITS - 16;
    logic signed [T_W:0] t_sum;
    logic [S_W:0]        s_sum;
    assign t_sum = (T_W+1)'(in_temperature) + (T_W+1)'(1 << (K - 1));
    assign s_sum = (S_W+1)'(in_salinity) + (S_W+1)'(1 << (K - 1));
    assign t16_c = T_W'(t_sum >>> K);
    assign s16_c = S_W'(s_sum >> K);
  end else begin : g_coarse
    localparam int UP = 16 - FRAC_BITS;
    localparam logic signed [T_W+1:0] T_LIM = (T_W+2)'(1) << (FRAC_BITS + 6);
    localparam logic        [S_W:0]   S_LIM = (S_W+1)'(1) << (FRAC_BITS + 6);
    logic signed [T_W+1:0] t_ext, t_sat;
    logic [S_W:0]          s_ext, s_sat;
    always_comb begin
      t_ext = (T_W+2)'(in_temperature);
      s_ext = (S_W+1)'(in_salinity);
      if (t_ext < -T_LIM) begin
        t_sat = -T_LIM;
      end else if (t_ext > T_LIM - 1) begin
        t_sat = T_LIM - 1;
      end else begin
        t_sat = t_ext;
      end
      if (s_ext > S_LIM - 1) begin
        s_sat = S_LIM - 1;
      end else begin
        s_sat = s_ext;
      end
    end
    assign t16_c = T_W'(t_sat <<< UP);
    assign s16_c = S_W'(s_sat << UP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= t16_c;
      s0_r <= s16_c;
    end
  end

  // The root of salinity starts from the conditioned input so that it lands
  // next to the third polynomial stage, where it is first needed.
  sdre_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .s_in     (s16_c),
    .root_out (root)
  );

  sdre_poly u_poly (
    .clk     (clk),
    .en      (en),
    .t_in    (t0_r),
    .s_in    (s0_r),
    .root_in (root),
    .num_out (num),
    .den_out (den)
  );

  sdre_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .en       (en),
    .num_in   (num),
    .den_in   (den),
    .q_out    (q),
    .flag_out (flag)
  );

  // Drop the guard bit with round half up, then apply the special cases:
  // a non-positive denominator or anything out of range saturates, else a non-positive
  // numerator gives zero. The quotient carries no meaning when the numerator is
  // non-positive, so its overflow bit is only looked at after the zero case.
  assign q_sum = {1'b0, q} + (QB+1)'(1);
  assign q_rnd = q_sum[QB:1];

  always_comb begin
    if (flag.sat) begin
      dens_nxt = '1;
    end else if (flag.zero) begin
      dens_nxt = '0;
    end else if (q_rnd[QB-1]) begin
      dens_nxt = '1;
    end else begin
      dens_nxt = q_rnd[sdre_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens_r <= dens_nxt;
    end
  end

  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_density = dens_r;

endmodule

`default_nettype wire
